FILE: src/bfgr_pkg.sv
package bfgr_pkg;

	// default sizes
	localparam int STRIKE_BYTES_DEF = 16384;
	localparam int MAX_ROWS_DEF     = 32;
	localparam int MAX_WIDTH_DEF    = 32;
	localparam int CHAR_CODES_DEF   = 256;

	// field widths
	localparam int KIND_W     = 2;
	localparam int SADDR_W    = 14;
	localparam int BYTE_W     = 8;
	localparam int CODE_W     = 8;
	localparam int START_W    = 13;
	localparam int BCNT_W     = 6;
	localparam int COORD_W    = 16;
	localparam int MASK_W     = 32;
	localparam int ROWCNT_W   = 6;
	localparam int STRIDE_W   = 11;
	localparam int ROWS_W     = 7;
	localparam int LOC_W      = START_W + BCNT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_LOAD_BYTE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOAD_LOC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAW      = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LO_CHAR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HI_CHAR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE = 2'd3;

	// register reset values
	localparam logic [CODE_W-1:0]   LO_CHAR_RST    = 8'd32;
	localparam logic [CODE_W-1:0]   HI_CHAR_RST    = 8'd255;
	localparam logic [ROWCNT_W-1:0] ROW_COUNT_RST  = 6'd8;
	localparam logic [STRIDE_W-1:0] ROW_STRIDE_RST = 11'd192;

	// controller -> datapath
	typedef struct packed {
		logic take_load;
		logic loc_write;
		logic take_draw;
		logic setup;
		logic addr_sub;
		logic mem_write;
		logic row_begin;
		logic capture;
		logic emit;
		logic next_row;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic draw_ok;
		logic addr_ge;
		logic no_bytes;
		logic last_byte;
		logic last_row;
	} status_t;

endpackage

FILE: src/bitmap_font_glyph_raster_top.sv
// Draw: after the accept, the location entry is set up; each row then wraps its base
// address into the strike, reads B = ceil((start%8 + width)/8) strike bytes
// (an issue and a capture state per byte) and is emitted as a registered result.
// Strike byte load: address wrapped below STRIKE_BYTES, then the byte is written;
// location load: accept cycle. Strike reads set the row time; results cannot stall.
// Reset: config registers to defaults, state to idle; strike and table are not cleared.
module bitmap_font_glyph_raster_top
	import bfgr_pkg::*;
#(
	parameter int STRIKE_BYTES = STRIKE_BYTES_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF,
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int CHAR_CODES   = CHAR_CODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [KIND_W-1:0]         kind,
	input  logic [SADDR_W-1:0]        strike_address,
	input  logic [BYTE_W-1:0]         strike_byte,
	input  logic [CODE_W-1:0]         char_code,
	input  logic [START_W-1:0]        bit_offset_start,
	input  logic [BCNT_W-1:0]         bit_count,
	input  logic signed [COORD_W-1:0] origin_x,
	input  logic signed [COORD_W-1:0] origin_y,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	output logic                      result_strobe,
	output logic signed [COORD_W-1:0] pixel_x,
	output logic signed [COORD_W-1:0] pixel_y,
	output logic [MASK_W-1:0]         row_mask,
	output logic                      last
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	bfgr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (kind),
		.status (status),
		.busy   (busy),
		.cmd    (cmd)
	);

	// stores, address arithmetic and row assembly
	bfgr_dp #(
		.STRIKE_BYTES (STRIKE_BYTES),
		.MAX_ROWS     (MAX_ROWS),
		.MAX_WIDTH    (MAX_WIDTH),
		.CHAR_CODES   (CHAR_CODES)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.strike_address   (strike_address),
		.strike_byte      (strike_byte),
		.char_code        (char_code),
		.bit_offset_start (bit_offset_start),
		.bit_count        (bit_count),
		.origin_x         (origin_x),
		.origin_y         (origin_y),
		.result_strobe    (result_strobe),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.row_mask         (row_mask),
		.last             (last)
	);

endmodule

FILE: src/bfgr_ctrl.sv
module bfgr_ctrl
	import bfgr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  status_t           status,
	output logic              busy,
	output cmd_t              cmd
);

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_RED_LD  = 7'b0000010,
		S_LOC     = 7'b0000100,
		S_RED_ROW = 7'b0001000,
		S_ISSUE   = 7'b0010000,
		S_CAPTURE = 7'b0100000,
		S_EMIT    = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_LOAD_BYTE: begin
							cmd.take_load = 1'b1;
							state_d       = S_RED_LD;
						end
						KIND_LOAD_LOC: begin
							cmd.loc_write = 1'b1;
						end
						KIND_DRAW: begin
							if (status.draw_ok) begin
								cmd.take_draw = 1'b1;
								state_d       = S_LOC;
							end
						end
						default: ;
					endcase
				end
			end
			// wrap the load address, then write
			S_RED_LD: begin
				if (status.addr_ge) begin
					cmd.addr_sub = 1'b1;
				end else begin
					cmd.mem_write = 1'b1;
					state_d       = S_IDLE;
				end
			end
			// location entry is in its read register
			S_LOC: begin
				cmd.setup = 1'b1;
				state_d   = S_RED_ROW;
			end
			// wrap the row base address
			S_RED_ROW: begin
				if (status.addr_ge) begin
					cmd.addr_sub = 1'b1;
				end else begin
					cmd.row_begin = 1'b1;
					state_d       = status.no_bytes ? S_EMIT : S_ISSUE;
				end
			end
			S_ISSUE: begin
				state_d = S_CAPTURE;
			end
			S_CAPTURE: begin
				cmd.capture = 1'b1;
				state_d     = status.last_byte ? S_EMIT : S_ISSUE;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				if (status.last_row) begin
					state_d = S_IDLE;
				end else begin
					cmd.next_row = 1'b1;
					state_d      = S_RED_ROW;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	// byte capture always follows its read cycle
	a_capture_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CAPTURE |-> $past(state_q == S_ISSUE))
		else $error("capture without preceding read");

	// last row returns to idle
	a_last_row_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && status.last_row) |=> state_q == S_IDLE)
		else $error("glyph did not end after last row");

	// rejected draw stays idle
	a_reject_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && kind == KIND_DRAW && !status.draw_ok)
		|=> state_q == S_IDLE)
		else $error("out of range draw started");

	// a reduced load address writes and ends
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED_LD && !status.addr_ge) |-> cmd.mem_write)
		else $error("load byte not written");

endmodule

FILE: src/bfgr_dp.sv
module bfgr_dp
	import bfgr_pkg::*;
#(
	parameter int STRIKE_BYTES = STRIKE_BYTES_DEF,
	parameter int MAX_ROWS     = MAX_ROWS_DEF,
	parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
	parameter int CHAR_CODES   = CHAR_CODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output status_t                   status,
	input  logic                      cfg_write,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [SADDR_W-1:0]        strike_address,
	input  logic [BYTE_W-1:0]         strike_byte,
	input  logic [CODE_W-1:0]         char_code,
	input  logic [START_W-1:0]        bit_offset_start,
	input  logic [BCNT_W-1:0]         bit_count,
	input  logic signed [COORD_W-1:0] origin_x,
	input  logic signed [COORD_W-1:0] origin_y,
	output logic                      result_strobe,
	output logic signed [COORD_W-1:0] pixel_x,
	output logic signed [COORD_W-1:0] pixel_y,
	output logic [MASK_W-1:0]         row_mask,
	output logic                      last
);

	localparam int ADDR_W   = $clog2(STRIKE_BYTES);
	localparam int SUM_W    = ((ADDR_W > SADDR_W) ? ADDR_W : SADDR_W) + 1;
	localparam int CIDX_W   = $clog2(CHAR_CODES);
	localparam int NB       = (MAX_WIDTH + 14) / 8;
	localparam int NB_W     = $clog2(NB + 1);
	localparam int WIN_W    = NB * 8;
	localparam int OUT_COLS = (MAX_WIDTH < MASK_W) ? MAX_WIDTH : MASK_W;

	// configuration
	logic [CODE_W-1:0]   lo_q, hi_q;
	logic [ROWCNT_W-1:0] rowcnt_q;
	logic [STRIDE_W-1:0] stride_q;

	// stores
	logic [BYTE_W-1:0] strike_mem [STRIKE_BYTES];
	logic [LOC_W-1:0]  loc_mem [CHAR_CODES];
	logic [BYTE_W-1:0] rdata_q;
	logic [LOC_W-1:0]  loc_rd_q;

	// working registers
	logic [SUM_W-1:0]          addr_q;
	logic [BYTE_W-1:0]         byte_q;
	logic [ADDR_W-1:0]         row_base_q, rd_addr_q, rd_addr_next;
	logic [2:0]                sub_q;
	logic [BCNT_W-1:0]         width_q;
	logic [NB_W-1:0]           nbytes_q, bcnt_q;
	logic [WIN_W-1:0]          window_q, window_d, shifted;
	logic signed [COORD_W-1:0] ox_q, y_q;
	logic [ROWS_W-1:0]         rows_q, row_idx_q, rows_eff;
	logic [MASK_W-1:0]         mask_d;
	logic                      strobe_q, last_q;
	logic signed [COORD_W-1:0] pixel_x_q, pixel_y_q;
	logic [MASK_W-1:0]         mask_q;

	// location entry fields and derived values
	logic [START_W-1:0] loc_start;
	logic [BCNT_W-1:0]  loc_width, width_clamped;
	logic [7:0]         span;
	logic               code_ok;

	assign loc_start = loc_rd_q[LOC_W-1:BCNT_W];
	assign loc_width = loc_rd_q[BCNT_W-1:0];
	assign span      = 8'(loc_start[2:0]) + 8'(loc_width) + 8'd7;

	assign width_clamped = ({1'b0, bit_count} > 7'(MAX_WIDTH)) ? BCNT_W'(MAX_WIDTH) : bit_count;
	assign rows_eff = ({1'b0, rowcnt_q} > ROWS_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
		: {1'b0, rowcnt_q};
	assign code_ok = (char_code >= lo_q) && (char_code <= hi_q)
		&& ({1'b0, char_code} < 9'(CHAR_CODES));

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q     <= LO_CHAR_RST;
			hi_q     <= HI_CHAR_RST;
			rowcnt_q <= ROW_COUNT_RST;
			stride_q <= ROW_STRIDE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LO_CHAR:    lo_q     <= cfg_data[CODE_W-1:0];
				CFG_HI_CHAR:    hi_q     <= cfg_data[CODE_W-1:0];
				CFG_ROW_COUNT:  rowcnt_q <= cfg_data[ROWCNT_W-1:0];
				CFG_ROW_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// strike memory
	always_ff @(posedge clk) begin
		if (cmd.mem_write) begin
			strike_mem[addr_q[ADDR_W-1:0]] <= byte_q;
		end
		rdata_q <= strike_mem[rd_addr_q];
	end

	// location table
	always_ff @(posedge clk) begin
		if (cmd.loc_write && ({1'b0, char_code} < 9'(CHAR_CODES))) begin
			loc_mem[char_code[CIDX_W-1:0]] <= {bit_offset_start, width_clamped};
		end
		loc_rd_q <= loc_mem[char_code[CIDX_W-1:0]];
	end

	// byte address walk within a row
	assign rd_addr_next = (rd_addr_q == ADDR_W'(STRIKE_BYTES - 1)) ? '0
		: rd_addr_q + ADDR_W'(1);

	// drop the fetched byte into its slot, MSB-first
	always_comb begin
		window_d = window_q;
		for (int j = 0; j < NB; j++) begin
			if (bcnt_q == NB_W'(j)) begin
				window_d[WIN_W-1-8*j -: 8] = rdata_q;
			end
		end
	end

	// align to the first bit column and pick out the glyph's columns
	assign shifted = window_q << sub_q;
	always_comb begin
		mask_d = '0;
		for (int c = 0; c < OUT_COLS; c++) begin
			mask_d[c] = shifted[WIN_W-1-c] && (7'(c) < {1'b0, width_q});
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd.take_load) begin
			addr_q <= SUM_W'(strike_address);
			byte_q <= strike_byte;
		end
		if (cmd.take_draw) begin
			ox_q      <= origin_x;
			y_q       <= origin_y;
			rows_q    <= rows_eff;
			row_idx_q <= '0;
		end
		if (cmd.setup) begin
			sub_q    <= loc_start[2:0];
			width_q  <= loc_width;
			nbytes_q <= NB_W'(span >> 3);
			addr_q   <= SUM_W'(loc_start >> 3);
		end
		if (cmd.addr_sub) begin
			addr_q <= addr_q - SUM_W'(STRIKE_BYTES);
		end
		if (cmd.row_begin) begin
			row_base_q <= addr_q[ADDR_W-1:0];
			rd_addr_q  <= addr_q[ADDR_W-1:0];
			bcnt_q     <= '0;
			window_q   <= '0;
		end
		if (cmd.capture) begin
			window_q  <= window_d;
			bcnt_q    <= bcnt_q + NB_W'(1);
			rd_addr_q <= rd_addr_next;
		end
		if (cmd.emit) begin
			pixel_x_q <= ox_q;
			pixel_y_q <= y_q;
			mask_q    <= mask_d;
			last_q    <= status.last_row;
		end
		if (cmd.next_row) begin
			addr_q    <= SUM_W'(row_base_q) + SUM_W'(stride_q);
			row_idx_q <= row_idx_q + ROWS_W'(1);
			y_q       <= y_q + 16'sd1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	// status back to the controller
	assign status.draw_ok   = code_ok && (rows_eff != '0);
	assign status.addr_ge   = (addr_q >= SUM_W'(STRIKE_BYTES));
	assign status.no_bytes  = (nbytes_q == '0);
	assign status.last_byte = ((bcnt_q + NB_W'(1)) == nbytes_q);
	assign status.last_row  = ((row_idx_q + ROWS_W'(1)) == rows_q);

	assign result_strobe = strobe_q;
	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign row_mask      = mask_q;
	assign last          = last_q;

endmodule
